FILE: rtl/avr_pkg.sv
// ----------------------------------------------------------------------------
// Axis-angle vector rotation: shared package
// Types, fixed-point constants and the arctangent table used by the angle
// reduction, CORDIC and rotation pipelines.
// ----------------------------------------------------------------------------
package avr_pkg;

  typedef enum logic {
    KIND_AXIS  = 1'b0,
    KIND_EULER = 1'b1
  } kind_e;

  // Q16.16 vector, x in the lowest bits when packed.
  typedef struct packed {
    logic signed [31:0] z;
    logic signed [31:0] y;
    logic signed [31:0] x;
  } vec_t;

  // Width of the Q.30 radian value during range reduction.
  localparam int unsigned ANG_W     = 48;
  // Compare-and-subtract steps of the modulo 2*pi reduction.
  localparam int unsigned RED_STEPS = 14;
  localparam int unsigned ANG_LAT   = RED_STEPS + 3;
  localparam int unsigned ROT_LAT   = 5;
  localparam int unsigned ATAN_LEN  = 30;

  localparam logic signed [ANG_W-1:0] Q30_PI      = 48'sd3373259426;
  localparam logic signed [ANG_W-1:0] Q30_TWO_PI  = 48'sd6746518852;
  localparam logic signed [ANG_W-1:0] Q30_HALF_PI = 48'sd1686629713;
  // A multiple of 2*pi that makes every reachable angle non-negative.
  localparam logic signed [ANG_W-1:0] RED_OFFSET  = Q30_TWO_PI <<< (RED_STEPS - 1);

  localparam logic signed [27:0] DEG_TO_RAD  = 28'sd74961321;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [15:0] AXIS_ONE    = 16'sd16384;

  localparam logic [29:0] ATAN_Q30 [ATAN_LEN] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515,  30'd16775850,  30'd8388437,   30'd4194282,   30'd2097149,
    30'd1048575,   30'd524287,    30'd262143,    30'd131071,    30'd65535,
    30'd32767,     30'd16383,     30'd8191,      30'd4095,      30'd2047,
    30'd1023,      30'd511,       30'd255,       30'd127,       30'd63,
    30'd31,        30'd15,        30'd7,         30'd3,         30'd1
  };

endpackage

FILE: rtl/axis_angle_vector_rotation.sv
// ----------------------------------------------------------------------------
// Axis-angle vector rotation
// Rotates a Q16.16 vector about a Q2.14 axis by one angle, or by three Euler
// angles (Y, then Z, then X), with CORDIC sine and cosine.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Content
//  s_axis    in         tdata: vectors, axis, angles; tuser: item kind
//  m_axis    out        tdata: rotated vector out_x, out_y, out_z
//  cfg       in         one-bit write of angle_in_degrees
//
// A transfer can be accepted on every cycle unless the output stalls. An input
// transfer passes through angle conversion and the fourteen-step modulo 2*pi
// reduction, then the CORDIC micro-rotations and the rounding of sine and
// cosine, then the rotation units, of which there are three in series for
// the Euler chain.
// A stall on the output freezes the whole pipeline in place; nothing is lost
// or repeated. Reset clears the valid bits and the degrees flag only.
//
// The three angle lanes work in parallel. Lane 0 carries the axis angle (or
// the Euler angle about Y), lane 1 the angle about Z and lane 2 the angle
// about X. The sine and cosine of lanes 1 and 2 are delayed so that each
// meets the vector when the previous rotation unit has finished with it. In
// axis mode the second and third units pass the vector through unchanged.
// ----------------------------------------------------------------------------
module axis_angle_vector_rotation import avr_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 16,
  parameter int unsigned FRAC_BITS    = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_wdata_i,    // angle_in_degrees
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle_a, angle_b, angle_c
  input  logic [239:0] s_axis_tdata,
  input  logic         s_axis_tuser,   // kind
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [95:0]  m_axis_tdata    // out_x, out_y, out_z
);

  localparam int unsigned CS_W   = FRAC_BITS + 3;
  localparam int unsigned NSTEP  = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
  localparam int unsigned SC_LAT = ANG_LAT + NSTEP + 2;

  typedef struct packed {
    kind_e              kind;
    vec_t               vec;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
  } item_t;

  logic                   en;
  logic                   deg_q;
  kind_e                  kind_in;
  item_t                  item_d;
  item_t                  item_q [SC_LAT];
  logic signed [31:0]     lane_angle [3];
  logic [2:0]             ang_valid;
  logic signed [31:0]     ang_z [3];
  logic [2:0]             ang_neg;
  logic [2:0]             lane_valid;
  logic signed [CS_W-1:0] lane_cos [3];
  logic signed [CS_W-1:0] lane_sin [3];
  logic signed [CS_W-1:0] c1_q [ROT_LAT];
  logic signed [CS_W-1:0] s1_q [ROT_LAT];
  logic signed [CS_W-1:0] c2_q [2*ROT_LAT];
  logic signed [CS_W-1:0] s2_q [2*ROT_LAT];
  logic signed [15:0]     r0_ax;
  logic signed [15:0]     r0_ay;
  logic signed [15:0]     r0_az;
  logic                   rot0_valid;
  logic                   rot1_valid;
  kind_e                  rot0_kind;
  kind_e                  rot1_kind;
  vec_t                   rot0_vec;
  vec_t                   rot1_vec;
  vec_t                   rot2_vec;

  // The whole pipeline moves whenever the output register is free or being
  // emptied, so a new transfer is taken while a finished one is drained.
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deg_q <= 1'b0;
    end else if (cfg_we_i) begin
      deg_q <= cfg_wdata_i;
    end
  end

  // Unpack the input transfer.
  always_comb begin
    kind_in       = kind_e'(s_axis_tuser);
    item_d.kind   = kind_in;
    item_d.vec.x  = s_axis_tdata[31:0];
    item_d.vec.y  = s_axis_tdata[63:32];
    item_d.vec.z  = s_axis_tdata[95:64];
    item_d.ax     = s_axis_tdata[111:96];
    item_d.ay     = s_axis_tdata[127:112];
    item_d.az     = s_axis_tdata[143:128];
    lane_angle[0] = (kind_in == KIND_EULER) ? s_axis_tdata[207:176] : s_axis_tdata[175:144];
    lane_angle[1] = s_axis_tdata[239:208];
    lane_angle[2] = s_axis_tdata[175:144];
  end

  // The vector and axis wait here while the sines and cosines are computed.
  always_ff @(posedge clk_i) begin
    if (en) begin
      item_q[0] <= item_d;
      for (int i = 1; i < SC_LAT; i++) begin
        item_q[i] <= item_q[i-1];
      end
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    avr_angle u_angle (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .deg_i   (deg_q),
      .valid_i (s_axis_tvalid),
      .angle_i (lane_angle[l]),
      .valid_o (ang_valid[l]),
      .z_o     (ang_z[l]),
      .neg_o   (ang_neg[l])
    );

    avr_cordic #(
      .STEPS     (NSTEP),
      .FRAC_BITS (FRAC_BITS)
    ) u_cordic (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (ang_valid[l]),
      .z_i     (ang_z[l]),
      .neg_i   (ang_neg[l]),
      .valid_o (lane_valid[l]),
      .cos_o   (lane_cos[l]),
      .sin_o   (lane_sin[l])
    );
  end

  // Lanes 1 and 2 are held back by one and two rotation units.
  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_q[0] <= lane_cos[1];
      s1_q[0] <= lane_sin[1];
      for (int i = 1; i < ROT_LAT; i++) begin
        c1_q[i] <= c1_q[i-1];
        s1_q[i] <= s1_q[i-1];
      end
      c2_q[0] <= lane_cos[2];
      s2_q[0] <= lane_sin[2];
      for (int i = 1; i < 2*ROT_LAT; i++) begin
        c2_q[i] <= c2_q[i-1];
        s2_q[i] <= s2_q[i-1];
      end
    end
  end

  // The first unit takes the given axis in axis mode, the Y axis otherwise.
  always_comb begin
    if (item_q[SC_LAT-1].kind == KIND_EULER) begin
      r0_ax = '0;
      r0_ay = AXIS_ONE;
      r0_az = '0;
    end else begin
      r0_ax = item_q[SC_LAT-1].ax;
      r0_ay = item_q[SC_LAT-1].ay;
      r0_az = item_q[SC_LAT-1].az;
    end
  end

  avr_rotate #(.FRAC_BITS(FRAC_BITS)) u_rot0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (&lane_valid),
    .kind_i  (item_q[SC_LAT-1].kind),
    .pass_i  (1'b0),
    .vec_i   (item_q[SC_LAT-1].vec),
    .cos_i   (lane_cos[0]),
    .sin_i   (lane_sin[0]),
    .ax_i    (r0_ax),
    .ay_i    (r0_ay),
    .az_i    (r0_az),
    .valid_o (rot0_valid),
    .kind_o  (rot0_kind),
    .vec_o   (rot0_vec)
  );

  avr_rotate #(.FRAC_BITS(FRAC_BITS)) u_rot1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (rot0_valid),
    .kind_i  (rot0_kind),
    .pass_i  (rot0_kind == KIND_AXIS),
    .vec_i   (rot0_vec),
    .cos_i   (c1_q[ROT_LAT-1]),
    .sin_i   (s1_q[ROT_LAT-1]),
    .ax_i    (16'sd0),
    .ay_i    (16'sd0),
    .az_i    (AXIS_ONE),
    .valid_o (rot1_valid),
    .kind_o  (rot1_kind),
    .vec_o   (rot1_vec)
  );

  avr_rotate #(.FRAC_BITS(FRAC_BITS)) u_rot2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (rot1_valid),
    .kind_i  (rot1_kind),
    .pass_i  (rot1_kind == KIND_AXIS),
    .vec_i   (rot1_vec),
    .cos_i   (c2_q[2*ROT_LAT-1]),
    .sin_i   (s2_q[2*ROT_LAT-1]),
    .ax_i    (AXIS_ONE),
    .ay_i    (16'sd0),
    .az_i    (16'sd0),
    .valid_o (m_axis_tvalid),
    .kind_o  (),
    .vec_o   (rot2_vec)
  );

  assign m_axis_tdata = rot2_vec;

`ifndef ASSERT_OFF
  // The three angle lanes run in lock step, so their valid bits agree.
  a_lane_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lane_valid == 3'b000) || (lane_valid == 3'b111))
    else $error("angle lanes out of step");

  // A stall freezes the rotation chain.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |=> $stable({rot0_valid, rot1_valid, m_axis_tvalid}))
    else $error("rotation chain moved during a stall");
`endif

endmodule

FILE: rtl/avr_angle.sv
// ----------------------------------------------------------------------------
// Angle conversion and range reduction
// Converts a Q16.16 angle to Q.30 radians, reduces it modulo 2*pi one
// compare-and-subtract per stage and folds it into [-pi/2, pi/2].
// ----------------------------------------------------------------------------
module avr_angle import avr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               deg_i,
  input  logic               valid_i,
  input  logic signed [31:0] angle_i,
  output logic               valid_o,
  output logic signed [31:0] z_o,
  output logic               neg_o
);

  localparam int unsigned PROD_W = 60;
  localparam logic signed [PROD_W-1:0] HALF_18 = PROD_W'(1) <<< 17;

  logic [ANG_LAT-1:0]        valid_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [31:0]        angle_q;
  logic                      deg_q;
  logic signed [ANG_W-1:0]   red_q [RED_STEPS+1];
  logic signed [PROD_W-1:0]  deg_rad;
  logic signed [ANG_W-1:0]   rad_d;
  logic signed [ANG_W-1:0]   cen_d;
  logic signed [ANG_W-1:0]   fold_d;
  logic                      neg_d;
  logic signed [31:0]        z_q;
  logic                      neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[ANG_LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= angle_i * DEG_TO_RAD;
      angle_q <= angle_i;
      deg_q   <= deg_i;
    end
  end

  always_comb begin
    deg_rad = (prod_q + HALF_18) >>> 18;
    if (deg_q) begin
      rad_d = ANG_W'(deg_rad);
    end else begin
      rad_d = ANG_W'(angle_q) <<< 14;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      red_q[0] <= rad_d + Q30_PI + RED_OFFSET;
    end
  end

  for (genvar k = 0; k < RED_STEPS; k++) begin : g_red
    localparam logic signed [ANG_W-1:0] SUB = Q30_TWO_PI <<< (RED_STEPS - 1 - k);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        red_q[k+1] <= (red_q[k] >= SUB) ? red_q[k] - SUB : red_q[k];
      end
    end
  end

  // Centre on zero, then fold the outer quarters onto the inner half turn.
  always_comb begin
    cen_d = red_q[RED_STEPS] - Q30_PI;
    priority if (cen_d > Q30_HALF_PI) begin
      fold_d = Q30_PI - cen_d;
      neg_d  = 1'b1;
    end else if (cen_d < -Q30_HALF_PI) begin
      fold_d = -Q30_PI - cen_d;
      neg_d  = 1'b1;
    end else begin
      fold_d = cen_d;
      neg_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z_q   <= 32'(fold_d);
      neg_q <= neg_d;
    end
  end

  assign valid_o = valid_q[ANG_LAT-1];
  assign z_o     = z_q;
  assign neg_o   = neg_q;

endmodule

FILE: rtl/avr_cordic.sv
// ----------------------------------------------------------------------------
// Pipelined rotation-mode CORDIC
// One micro-rotation per stage in Q.30, then rounding of cosine and sine to
// FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
module avr_cordic import avr_pkg::*; #(
  parameter  int unsigned STEPS     = 16,
  parameter  int unsigned FRAC_BITS = 16,
  localparam int unsigned CS_W      = FRAC_BITS + 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [31:0]   z_i,
  input  logic                 neg_i,
  output logic                 valid_o,
  output logic signed [CS_W-1:0] cos_o,
  output logic signed [CS_W-1:0] sin_o
);

  localparam int unsigned NSTEP = (STEPS < ATAN_LEN) ? STEPS : ATAN_LEN;
  localparam int unsigned CW    = 34;
  localparam int unsigned SH    = 30 - FRAC_BITS;
  localparam logic signed [CW-1:0] HALF_SH = CW'(1) <<< (SH - 1);

  logic [NSTEP+1:0]        valid_q;
  logic [NSTEP:0]          neg_q;
  logic signed [CW-1:0]    x_q [NSTEP+1];
  logic signed [CW-1:0]    y_q [NSTEP+1];
  logic signed [CW-1:0]    z_q [NSTEP+1];
  logic signed [CW-1:0]    xf;
  logic signed [CW-1:0]    xr;
  logic signed [CW-1:0]    yr;
  logic signed [CS_W-1:0]  cos_q;
  logic signed [CS_W-1:0]  sin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[NSTEP:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]   <= CORDIC_GAIN;
      y_q[0]   <= '0;
      z_q[0]   <= CW'(z_i);
      neg_q[0] <= neg_i;
    end
  end

  for (genvar i = 0; i < NSTEP; i++) begin : g_step
    localparam logic signed [CW-1:0] ATAN_I = {{(CW-30){1'b0}}, ATAN_Q30[i]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        neg_q[i+1] <= neg_q[i];
        if (!z_q[i][CW-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - ATAN_I;
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + ATAN_I;
        end
      end
    end
  end

  always_comb begin
    xf = neg_q[NSTEP] ? -x_q[NSTEP] : x_q[NSTEP];
    xr = (xf + HALF_SH) >>> SH;
    yr = (y_q[NSTEP] + HALF_SH) >>> SH;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_q <= CS_W'(xr);
      sin_q <= CS_W'(yr);
    end
  end

  assign valid_o = valid_q[NSTEP+1];
  assign cos_o   = cos_q;
  assign sin_o   = sin_q;

endmodule

FILE: rtl/avr_rotate.sv
// ----------------------------------------------------------------------------
// Rotation matrix and matrix-vector product
// Builds the axis-angle matrix from cos, sin and 1-cos, then multiplies the
// vector by it with rounding and saturation to Q16.16, in five stages.
// ----------------------------------------------------------------------------
module avr_rotate import avr_pkg::*; #(
  parameter  int unsigned FRAC_BITS = 16,
  localparam int unsigned CS_W      = FRAC_BITS + 3
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  kind_e                  kind_i,
  input  logic                   pass_i,
  input  vec_t                   vec_i,
  input  logic signed [CS_W-1:0] cos_i,
  input  logic signed [CS_W-1:0] sin_i,
  input  logic signed [15:0]     ax_i,
  input  logic signed [15:0]     ay_i,
  input  logic signed [15:0]     az_i,
  output logic                   valid_o,
  output kind_e                  kind_o,
  output vec_t                   vec_o
);

  localparam int unsigned Q_W = 16 + CS_W;
  localparam int unsigned D_W = 32 + CS_W;
  localparam int unsigned S_W = D_W + 2;
  localparam int unsigned M_W = FRAC_BITS + 5;
  localparam int unsigned P_W = 32 + M_W;
  localparam int unsigned A_W = P_W + 2;

  localparam logic signed [CS_W-1:0] ONE_F  = CS_W'(1) <<< FRAC_BITS;
  localparam logic signed [S_W-1:0]  HALF_M = S_W'(1) <<< 27;
  localparam logic signed [A_W-1:0]  HALF_F = A_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [A_W-1:0]  MAX32  = A_W'(32'sh7fffffff);
  localparam logic signed [A_W-1:0]  MIN32  = A_W'(32'sh80000000);

  logic [ROT_LAT-1:0]      valid_q;
  logic [ROT_LAT-1:0]      pass_q;
  kind_e                   kind_q [ROT_LAT];
  vec_t                    vec_q  [4];
  logic signed [31:0]      pp_q   [6];
  logic signed [Q_W-1:0]   q1_q   [3];
  logic signed [Q_W-1:0]   q2_q   [3];
  logic signed [CS_W-1:0]  c1_q;
  logic signed [CS_W-1:0]  c2_q;
  logic signed [CS_W-1:0]  t1_q;
  logic signed [D_W-1:0]   d_q    [6];
  logic signed [M_W-1:0]   m_q    [9];
  logic signed [P_W-1:0]   pr_q   [9];
  logic signed [S_W-1:0]   cd;
  logic signed [S_W-1:0]   qx;
  logic signed [S_W-1:0]   qy;
  logic signed [S_W-1:0]   qz;
  vec_t                    out_q;
  vec_t                    out_d;

  function automatic logic signed [M_W-1:0] rnd_m(input logic signed [S_W-1:0] v);
    logic signed [S_W-1:0] r;
    r = (v + HALF_M) >>> 28;
    return M_W'(r);
  endfunction

  function automatic logic signed [31:0] rnd_sat(input logic signed [P_W-1:0] a0,
                                                 input logic signed [P_W-1:0] a1,
                                                 input logic signed [P_W-1:0] a2);
    logic signed [A_W-1:0] r;
    logic signed [31:0]    res;
    r = (A_W'(a0) + A_W'(a1) + A_W'(a2) + HALF_F) >>> FRAC_BITS;
    priority if (r > MAX32) begin
      res = 32'sh7fffffff;
    end else if (r < MIN32) begin
      res = 32'sh80000000;
    end else begin
      res = 32'(r);
    end
    return res;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[ROT_LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pass_q    <= {pass_q[ROT_LAT-2:0], pass_i};
      kind_q[0] <= kind_i;
      for (int i = 1; i < ROT_LAT; i++) begin
        kind_q[i] <= kind_q[i-1];
      end
      vec_q[0] <= vec_i;
      for (int i = 1; i < 4; i++) begin
        vec_q[i] <= vec_q[i-1];
      end
    end
  end

  // Stage 1: axis products, axis times sine, 1 - cos.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_q[0] <= ax_i * ax_i;
      pp_q[1] <= ax_i * ay_i;
      pp_q[2] <= ax_i * az_i;
      pp_q[3] <= ay_i * ay_i;
      pp_q[4] <= ay_i * az_i;
      pp_q[5] <= az_i * az_i;
      q1_q[0] <= ax_i * sin_i;
      q1_q[1] <= ay_i * sin_i;
      q1_q[2] <= az_i * sin_i;
      c1_q    <= cos_i;
      t1_q    <= ONE_F - cos_i;
    end
  end

  // Stage 2: scale the axis products by 1 - cos.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 6; i++) begin
        d_q[i] <= pp_q[i] * t1_q;
      end
      q2_q <= q1_q;
      c2_q <= c1_q;
    end
  end

  // Stage 3: matrix entries, rounded to FRAC_BITS fraction bits.
  always_comb begin
    cd = S_W'(c2_q) <<< 28;
    qx = S_W'(q2_q[0]) <<< 14;
    qy = S_W'(q2_q[1]) <<< 14;
    qz = S_W'(q2_q[2]) <<< 14;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q[0] <= rnd_m(S_W'(d_q[0]) + cd);
      m_q[1] <= rnd_m(S_W'(d_q[1]) - qz);
      m_q[2] <= rnd_m(S_W'(d_q[2]) + qy);
      m_q[3] <= rnd_m(S_W'(d_q[1]) + qz);
      m_q[4] <= rnd_m(S_W'(d_q[3]) + cd);
      m_q[5] <= rnd_m(S_W'(d_q[4]) - qx);
      m_q[6] <= rnd_m(S_W'(d_q[2]) - qy);
      m_q[7] <= rnd_m(S_W'(d_q[4]) + qx);
      m_q[8] <= rnd_m(S_W'(d_q[5]) + cd);
    end
  end

  // Stage 4: the nine products of the matrix-vector multiply.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        pr_q[3*k]   <= vec_q[2].x * m_q[3*k];
        pr_q[3*k+1] <= vec_q[2].y * m_q[3*k+1];
        pr_q[3*k+2] <= vec_q[2].z * m_q[3*k+2];
      end
    end
  end

  // Stage 5: dot products, or the vector unchanged for a skipped rotation.
  always_comb begin
    if (pass_q[ROT_LAT-2]) begin
      out_d = vec_q[3];
    end else begin
      out_d.x = rnd_sat(pr_q[0], pr_q[1], pr_q[2]);
      out_d.y = rnd_sat(pr_q[3], pr_q[4], pr_q[5]);
      out_d.z = rnd_sat(pr_q[6], pr_q[7], pr_q[8]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= out_d;
    end
  end

  assign valid_o = valid_q[ROT_LAT-1];
  assign kind_o  = kind_q[ROT_LAT-1];
  assign vec_o   = out_q;

endmodule
